// ----- rtl/dtgl_pkg.sv -----
// shared types and constants for the depth to grayscale level block
`default_nettype none
package dtgl_pkg;

    localparam int DIST_W    = 32;
    localparam int QUOT_W    = 16;
    localparam int FRAC_W    = 17;
    localparam int LEVEL_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 17;
    localparam int STEP_W    = 4;

    localparam logic [FRAC_W-1:0]  ONE_Q16       = 17'd65536;
    localparam logic [20:0]        HALF_Q16      = 21'd32768;
    localparam logic [FRAC_W-1:0]  FLOOR_RESET   = 17'd6554;
    localparam logic [LEVEL_W-1:0] TOP_RESET     = 4'd10;
    localparam logic [STEP_W-1:0]  LAST_STEP     = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_FLOOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL        = 1'd1;

    localparam logic MODE_GATHER  = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } t_dtgl_state;

    typedef struct packed {
        logic capture;
        logic gather;
        logic setup;
        logic step;
        logic finish;
    } t_dtgl_cmd;

    typedef struct packed {
        logic last_step;
        logic out_free;
    } t_dtgl_status;

endpackage
`default_nettype wire

// ----- rtl/dtgl_ctrl.sv -----
// controller state machine: input handshake, division sequencing, result hand-off
`default_nettype none
module dtgl_ctrl import dtgl_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    input  wire          i_mode,
    input  wire t_dtgl_status i_status,
    output logic         o_ready,
    output t_dtgl_cmd    o_cmd
);

    t_dtgl_state r_state;
    t_dtgl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_mode == MODE_CONVERT) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.last_step) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.capture  = i_valid && (i_mode == MODE_CONVERT);
                o_cmd.gather   = i_valid && (i_mode == MODE_GATHER);
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    a_capture_to_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == ST_SETUP)
        else $error("convert word did not start setup");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.last_step) |=> r_state == ST_DONE)
        else $error("division did not finish after last step");

    a_hold_until_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_status.out_free) |=> r_state == ST_DONE)
        else $error("result dropped while output register was full");

endmodule
`default_nettype wire

// ----- rtl/dtgl_datapath.sv -----
// datapath: statistics, config registers, serial divider, level mapping, output register
`default_nettype none
module dtgl_datapath import dtgl_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire t_dtgl_cmd       i_cmd,
    output t_dtgl_status         o_status,
    input  wire [DIST_W-1:0]     i_distance,
    input  wire                  i_first_of_frame,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_wdata,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output logic [LEVEL_W-1:0]   o_level,
    output logic                 o_hit
);

    logic [FRAC_W-1:0]  r_floor;
    logic [LEVEL_W-1:0] r_top;
    logic [DIST_W-1:0]  r_near;
    logic [DIST_W-1:0]  r_far;
    logic [DIST_W-1:0]  r_dist;
    logic [DIST_W-1:0]  r_rem;
    logic [DIST_W-1:0]  r_span;
    logic [QUOT_W-1:0]  r_quot;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_zero_ratio;
    logic               r_sat;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level;
    logic               r_hit;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RESET;
            r_top   <= TOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BRIGHTNESS_FLOOR: r_floor <= i_cfg_wdata;
                REG_TOP_LEVEL:        r_top   <= i_cfg_wdata[LEVEL_W-1:0];
                default:              r_top   <= r_top;
            endcase
        end
    end

    // min/max gathering
    logic [DIST_W-1:0] n_near;
    logic [DIST_W-1:0] n_far;
    logic [DIST_W-1:0] base_near;
    logic [DIST_W-1:0] base_far;

    always_comb begin
        base_near = i_first_of_frame ? '1 : r_near;
        base_far  = i_first_of_frame ? '0 : r_far;
        n_near    = base_near;
        n_far     = base_far;
        if (i_distance != '0 && i_distance < base_near) n_near = i_distance;
        if (i_distance > base_far)                      n_far  = i_distance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= '1;
            r_far  <= '0;
        end else if (i_cmd.gather) begin
            r_near <= n_near;
            r_far  <= n_far;
        end
    end

    // divider setup and one quotient bit per step
    logic [DIST_W-1:0] diff;
    logic [DIST_W-1:0] span;
    logic [DIST_W:0]   rem2;
    logic [DIST_W:0]   rem_sub;
    logic              ge;

    assign diff    = r_dist - r_near;
    assign span    = r_far - r_near;
    assign rem2    = {r_rem, 1'b0};
    assign rem_sub = rem2 - {1'b0, r_span};
    assign ge      = rem2 >= {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_dist <= i_distance;
        if (i_cmd.setup) begin
            r_zero_ratio <= (r_far <= r_near) || (r_dist <= r_near);
            r_sat        <= diff >= span;
            r_rem        <= diff;
            r_span       <= span;
        end else if (i_cmd.step) begin
            r_rem  <= ge ? rem_sub[DIST_W-1:0] : rem2[DIST_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.setup) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // brightness and level
    logic [FRAC_W-1:0]  ratio;
    logic [FRAC_W-1:0]  bright;
    logic [FRAC_W-1:0]  bright_cl;
    logic [20:0]        scaled;
    logic [4:0]         lv;
    logic [LEVEL_W-1:0] lv_cl;

    always_comb begin
        if (r_zero_ratio)  ratio = '0;
        else if (r_sat)    ratio = ONE_Q16;
        else               ratio = {1'b0, r_quot};
        bright    = ONE_Q16 - ratio;
        bright_cl = (bright <= r_floor) ? r_floor : bright;
        // times ten as shift-add, plus one half for round half up
        scaled    = ({4'd0, bright_cl} << 3) + ({4'd0, bright_cl} << 1) + HALF_Q16;
        lv        = scaled[20:16];
        lv_cl     = (lv > {1'b0, r_top}) ? r_top : lv[LEVEL_W-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_hit   <= r_dist != '0;
            r_level <= (r_dist != '0) ? lv_cl : '0;
        end
    end

    assign o_status.last_step = i_cmd.step && (r_cnt == LAST_STEP);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_level            = r_level;
    assign o_hit              = r_hit;

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished result not loaded");

    a_miss_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_hit) |-> r_level == '0)
        else $error("miss with nonzero level");

    a_count_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.last_step |=> r_cnt == '0)
        else $error("step counter out of sequence");

endmodule
`default_nettype wire

// ----- rtl/depth_to_grayscale_level.sv -----
// Maps ray-hit distances to grayscale levels by depth falloff. Each frame goes
// through twice: words with tuser mode 0 gather the nearest nonzero and farthest
// distance (tuser first_of_frame restarts them) as they are accepted and give no
// result; words with mode 1 give one result word each. A convert word passes
// through a setup state, the 16 step serial restoring divider that forms the
// falloff ratio and a mapping state that loads the result; the mapping state
// waits while the output register still holds an unaccepted result. A gather word
// is taken as soon as the block is idle. The input is accepted again once the
// result is loaded into the output register, while it waits there, so no new
// convert word is taken while the last is still in the divider.
`default_nettype none
module depth_to_grayscale_level import dtgl_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [31:0]           s_axis_tdata,  // [31:0] distance
    input  wire [1:0]            s_axis_tuser,  // [0] mode, [1] first_of_frame
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [3:0] level, [7:4] zero
    output logic [0:0]           m_axis_tuser,  // [0] hit
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_wdata
);

    t_dtgl_cmd          cmd;
    t_dtgl_status       status;
    logic [LEVEL_W-1:0] level;
    logic               hit;

    dtgl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_mode   (s_axis_tuser[0]),
        .i_status (status),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    dtgl_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_distance       (s_axis_tdata),
        .i_first_of_frame (s_axis_tuser[1]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_level          (level),
        .o_hit            (hit)
    );

    assign m_axis_tdata = {4'd0, level};
    assign m_axis_tuser = hit;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for depth_to_grayscale_level: scoreboard class plus stream drivers
module tb;
    import dtgl_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               hit;
    } t_level_word;

    class t_level_scoreboard;
        logic [FRAC_W-1:0]  floor_q16;
        logic [LEVEL_W-1:0] top;
        logic [DIST_W-1:0]  nearest;
        logic [DIST_W-1:0]  farthest;
        t_level_word        expected_levels[$];
        int                 errors;

        function new();
            floor_q16 = FLOOR_RESET;
            top       = TOP_RESET;
            nearest   = '1;
            farthest  = '0;
            errors    = 0;
        endfunction

        function void configure(logic [FRAC_W-1:0] new_floor, logic [LEVEL_W-1:0] new_top);
            floor_q16 = new_floor;
            top       = new_top;
        endfunction

        function logic [LEVEL_W-1:0] falloff_level(logic [DIST_W-1:0] d);
            logic [63:0] span;
            logic [63:0] ratio;
            logic [63:0] bright;
            logic [63:0] lv;
            ratio = 0;
            // degenerate range and nearer-than-nearest both leave the ratio at zero
            if (farthest > nearest && d > nearest) begin
                span  = {32'd0, farthest} - {32'd0, nearest};
                ratio = ({32'd0, d} - {32'd0, nearest}) << 16;
                ratio = ratio / span;
                if (ratio > 64'd65536) ratio = 64'd65536;
            end
            bright = 64'd65536 - ratio;
            // the floor wins even when it sits above one
            if (bright <= {47'd0, floor_q16}) bright = {47'd0, floor_q16};
            lv = (bright * 64'd10 + 64'd32768) >> 16;
            if (lv > {60'd0, top}) lv = {60'd0, top};
            return lv[LEVEL_W-1:0];
        endfunction

        function void note_word(logic mode, logic [DIST_W-1:0] d, logic first);
            t_level_word w;
            if (mode == MODE_GATHER) begin
                if (first) begin
                    nearest  = '1;
                    farthest = '0;
                end
                if (d != 0 && d < nearest) nearest = d;
                if (d > farthest) farthest = d;
            end else begin
                w.hit   = (d != 0);
                w.level = w.hit ? falloff_level(d) : '0;
                expected_levels = {expected_levels, w};
            end
        endfunction

        function void check_word(logic [7:0] data, logic hit);
            t_level_word w;
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected word, level %0d hit %0d", $time, data, hit);
                errors++;
                return;
            end
            w = expected_levels.pop_front();
            if (data != {4'd0, w.level}) begin
                $display("%0t: level expected %0d actual %0d", $time, w.level, data);
                errors++;
            end
            if (hit != w.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, w.hit, hit);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [31:0]          s_axis_tdata  = '0;  // [31:0] distance
    logic [1:0]           s_axis_tuser  = '0;  // [0] mode, [1] first_of_frame
    logic                 m_axis_tready = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire  [7:0]           m_axis_tdata;    // [3:0] level, [7:4] zero
    wire  [0:0]           m_axis_tuser;    // [0] hit

    t_level_scoreboard sb = new();
    int send_idle  = 0;
    int recv_stall = 0;
    int words_sent = 0;

    depth_to_grayscale_level dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser[0]);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    task automatic send_word(logic mode, logic [31:0] d, logic first);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {first, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(mode, d, first);
        words_sent++;
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_settle(logic [FRAC_W-1:0] new_floor, logic [LEVEL_W-1:0] new_top);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_BRIGHTNESS_FLOOR;
        i_cfg_wdata <= new_floor;
        @(posedge i_clk);
        i_cfg_idx   <= REG_TOP_LEVEL;
        i_cfg_wdata <= {13'd0, new_top};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.configure(new_floor, new_top);
    endtask

    function automatic logic [31:0] pick_distance(logic [31:0] base);
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return '1;
            2:       return $urandom_range(1, 255);
            3, 4, 5: return base + $urandom_range(0, 32'h3FFFF);
            default: return $urandom;
        endcase
    endfunction

    // one frame: gather pass then convert pass, with some stray and broken frames
    task automatic send_frame();
        logic [31:0] dists[8];
        logic [31:0] base;
        int          n;
        int          kind;
        n    = $urandom_range(1, 8);
        kind = $urandom_range(0, 9);
        base = $urandom;
        for (int i = 0; i < n; i++) dists[i] = pick_distance(base);
        if (kind == 0) begin
            send_word(1'($urandom_range(0, 1)), pick_distance(base),
                      1'($urandom_range(0, 1)));
        end else begin
            // kind 1 converts against stale statistics, kind 2 merges into the last frame
            if (kind != 1) begin
                for (int i = 0; i < n; i++) send_word(MODE_GATHER, dists[i], i == 0 && kind != 2);
            end
            for (int i = 0; i < n; i++) begin
                send_word(MODE_CONVERT,
                          ($urandom_range(0, 4) == 0) ? pick_distance(base) : dists[i],
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        int goal;
        bit paused;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // statistics straight out of reset form a degenerate range
        send_word(MODE_CONVERT, 32'd100, 1'b0);
        send_word(MODE_CONVERT, 32'd0, 1'b1);
        send_word(MODE_GATHER, 32'h0001_0000, 1'b1);
        send_word(MODE_GATHER, 32'd0, 1'b0);
        send_word(MODE_GATHER, 32'h0005_0000, 1'b0);
        send_word(MODE_CONVERT, 32'h0000_8000, 1'b0);
        send_word(MODE_CONVERT, 32'h0001_0000, 1'b0);
        send_word(MODE_CONVERT, 32'h0003_0000, 1'b1);
        send_word(MODE_CONVERT, 32'h0005_0000, 1'b0);
        send_word(MODE_CONVERT, 32'h0009_0000, 1'b0);
        send_word(MODE_CONVERT, 32'hFFFF_FFFF, 1'b0);
        send_word(MODE_CONVERT, 32'd0, 1'b0);
        // single distance: nearest equals farthest
        send_word(MODE_GATHER, 32'h0002_0000, 1'b1);
        send_word(MODE_CONVERT, 32'h0002_0000, 1'b0);
        send_word(MODE_CONVERT, 32'h0003_0000, 1'b0);
        // only misses gathered
        send_word(MODE_GATHER, 32'd0, 1'b1);
        send_word(MODE_CONVERT, 32'd1, 1'b0);
        // widest possible range
        send_word(MODE_GATHER, 32'hFFFF_FFFF, 1'b1);
        send_word(MODE_GATHER, 32'd1, 1'b0);
        send_word(MODE_CONVERT, 32'h8000_0000, 1'b0);
        send_word(MODE_CONVERT, 32'hFFFF_FFFF, 1'b0);

        for (int p = 0; p < 8; p++) begin
            wait_results();
            repeat (25) @(posedge i_clk);
            case (p)
                0:       cfg_settle(FLOOR_RESET, TOP_RESET);
                1:       cfg_settle('0, '0);
                2:       cfg_settle(ONE_Q16, TOP_RESET);
                3:       cfg_settle('1, 4'd5);
                default: cfg_settle(FRAC_W'(($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 131071)
                                            : $urandom_range(0, 65536)),
                                    LEVEL_W'($urandom_range(0, 15)));
            endcase
            case (p % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 77; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 77; end
                default: begin send_idle = 8;  recv_stall = 8;  end
            endcase
            goal   = words_sent + 48;
            paused = 0;
            while (words_sent < goal) begin
                // hold the sender until the output side has fully drained
                if (!paused && words_sent >= goal - 27) begin
                    wait_results();
                    paused = 1;
                end
                send_frame();
            end
        end

        wait_results();
        repeat (25) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule
